FILE: rtl/tile_background_video_unit_top_assert.svh
// Assertion macros for the tile background video unit.
// Each macro expects clk and rst_n to be in scope.
`ifndef TILE_BACKGROUND_VIDEO_UNIT_TOP_ASSERT_SVH
`define TILE_BACKGROUND_VIDEO_UNIT_TOP_ASSERT_SVH

`define TBVU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbvu: same-cycle check failed");

`define TBVU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbvu: next-cycle check failed");

`endif

FILE: rtl/tbvu_pkg.sv
package tbvu_pkg;

    typedef logic [1:0] req_type_t;
    typedef logic [2:0] reg_index_t;
    typedef logic [2:0] pend_t;

    localparam req_type_t REQ_READ  = 2'd0;
    localparam req_type_t REQ_WRITE = 2'd1;
    localparam req_type_t REQ_TICK  = 2'd2;

    localparam reg_index_t REG_CTRL   = 3'd0;
    localparam reg_index_t REG_MASK   = 3'd1;
    localparam reg_index_t REG_STATUS = 3'd2;
    localparam reg_index_t REG_SCROLL = 3'd5;
    localparam reg_index_t REG_ADDR   = 3'd6;
    localparam reg_index_t REG_DATA   = 3'd7;

    // Destination of a memory read whose data returns in the next cycle.
    localparam pend_t PEND_NONE = 3'd0;
    localparam pend_t PEND_ID   = 3'd1;
    localparam pend_t PEND_ATTR = 3'd2;
    localparam pend_t PEND_LO   = 3'd3;
    localparam pend_t PEND_HI   = 3'd4;
    localparam pend_t PEND_BUF  = 3'd5;

    localparam int PAT_AW = 13;
    localparam int NT_AW  = 11;
    localparam int PAL_AW = 5;

    // Entries 0x10, 0x14, 0x18 and 0x1C fold onto the backdrop entries.
    function automatic logic [PAL_AW-1:0] pal_index(logic [PAL_AW-1:0] a);
        logic [PAL_AW-1:0] r;
        r = a;
        if (a[4] && (a[1:0] == 2'd0))
        begin
            r = {1'b0, a[3:0]};
        end
        return r;
    endfunction

endpackage

FILE: rtl/tbvu_ifs.sv
interface tbvu_in_if;
    logic                 valid;
    logic                 ready;
    tbvu_pkg::req_type_t  req_type;
    tbvu_pkg::reg_index_t reg_index;
    logic [7:0]           write_data;

    modport source (output valid, output req_type, output reg_index, output write_data,
                    input ready);
    modport sink   (input valid, input req_type, input reg_index, input write_data,
                    output ready);
endinterface

interface tbvu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       pixel_valid;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [5:0] color_index;
    logic       nmi_raise;
    logic       frame_done;

    modport source (output valid, output read_data, output pixel_valid, output pixel_x,
                    output pixel_y, output color_index, output nmi_raise,
                    output frame_done, input ready);
    modport sink   (input valid, input read_data, input pixel_valid, input pixel_x,
                    input pixel_y, input color_index, input nmi_raise,
                    input frame_done, output ready);
endinterface

FILE: rtl/tile_background_video_unit_top.sv
// Results: a request's result is registered and is valid in the cycle after the request
// is accepted.
// Throughput: one request per cycle while the output is taken and no clearing pass runs;
// each memory has one access per request, and its read data is forwarded into the request that follows.
// Reset: asynchronous, active low; state and palette registers clear, then a clearing pass
// over all 8192 pattern addresses zeroes the pattern and nametable memories while no request is accepted.
`include "tile_background_video_unit_top_assert.svh"

module tile_background_video_unit_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    tbvu_in_if.sink      in_req,
    tbvu_out_if.source   out_res
);

    logic [7:0]  ctrl_reg, ctrl_next, mask_reg, mask_next, rbuf_reg, rbuf_next;
    logic [7:0]  id_reg, id_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [1:0]  attr_reg, attr_next;
    logic        vbl_reg, vbl_next, wtog_reg, wtog_next, mirr_reg;
    logic [14:0] v_reg, v_next, t_reg, t_next;
    logic [2:0]  fx_reg, fx_next;
    logic [15:0] spl_reg, spl_next, sph_reg, sph_next, sal_reg, sal_next, sah_reg, sah_next;
    logic [8:0]  line_reg, line_next, dot_reg, dot_next;
    tbvu_pkg::pend_t pend_reg, pend_next;
    logic        pend_pat_reg, pend_pat_next;
    logic [1:0]  pend_sh_reg, pend_sh_next;

    logic [7:0]  pal_reg [32];
    logic        pal_we;
    logic [4:0]  pal_wa;
    logic [7:0]  pal_wd;

    logic [7:0]  pat_mem [8192];
    logic [7:0]  pat_q, pat_wd;
    logic        pat_re, pat_we;
    logic [12:0] pat_ra, pat_wa;
    logic [7:0]  nt_mem [2048];
    logic [7:0]  nt_q, nt_wd;
    logic        nt_re, nt_we;
    logic [10:0] nt_ra, nt_wa;

    logic        clr_busy_reg;
    logic [12:0] clr_cnt_reg;

    logic        in_ready, accept;
    logic        out_valid_reg;
    logic [7:0]  rd_reg, rd_next, px_reg, px_next, py_reg, py_next;
    logic        pv_reg, pv_next, nmi_reg, nmi_next, fd_reg, fd_next;
    logic [5:0]  ci_reg, ci_next;

    logic [7:0]  mem_q, attr_a1;
    logic [1:0]  attr_fwd;

    assign in_ready = !clr_busy_reg && (!out_valid_reg || out_res.ready);
    assign accept   = in_req.valid && in_ready;
    assign in_req.ready = in_ready;

    // Read data of the previous cycle, shaped for its destination register.
    assign mem_q    = pend_pat_reg ? pat_q : nt_q;
    assign attr_a1  = pend_sh_reg[1] ? {4'd0, mem_q[7:4]} : mem_q;
    assign attr_fwd = pend_sh_reg[0] ? attr_a1[3:2] : attr_a1[1:0];

    always_comb
    begin
        logic [13:0] a14;
        logic [8:0]  line, dot, dm1;
        logic        render, window;
        logic [4:0]  cy;
        logic [3:0]  bi;
        logic [1:0]  pix, pal;
        logic [4:0]  pidx;
        logic [7:0]  pv8;

        ctrl_next = ctrl_reg;
        mask_next = mask_reg;
        vbl_next  = vbl_reg;
        wtog_next = wtog_reg;
        v_next    = v_reg;
        t_next    = t_reg;
        fx_next   = fx_reg;
        spl_next  = spl_reg;
        sph_next  = sph_reg;
        sal_next  = sal_reg;
        sah_next  = sah_reg;
        line_next = line_reg;
        dot_next  = dot_reg;
        id_next   = (pend_reg == tbvu_pkg::PEND_ID)   ? mem_q    : id_reg;
        attr_next = (pend_reg == tbvu_pkg::PEND_ATTR) ? attr_fwd : attr_reg;
        lo_next   = (pend_reg == tbvu_pkg::PEND_LO)   ? mem_q    : lo_reg;
        hi_next   = (pend_reg == tbvu_pkg::PEND_HI)   ? mem_q    : hi_reg;
        rbuf_next = (pend_reg == tbvu_pkg::PEND_BUF)  ? mem_q    : rbuf_reg;
        pend_next     = tbvu_pkg::PEND_NONE;
        pend_pat_next = 1'b0;
        pend_sh_next  = 2'd0;
        pat_re = 1'b0; pat_ra = '0; pat_we = 1'b0; pat_wa = '0; pat_wd = '0;
        nt_re  = 1'b0; nt_ra  = '0; nt_we  = 1'b0; nt_wa  = '0; nt_wd  = '0;
        pal_we = 1'b0; pal_wa = '0; pal_wd = '0;
        rd_next = '0; pv_next = 1'b0; px_next = '0; py_next = '0;
        ci_next = '0; nmi_next = 1'b0; fd_next = 1'b0;

        a14    = v_reg[13:0];
        render = mask_reg[4] || mask_reg[3];
        line   = line_reg;
        dot    = ((line_reg == 9'd0) && (dot_reg == 9'd0)) ? 9'd1 : dot_reg;
        dm1    = dot - 9'd1;
        window = ((dot >= 9'd2) && (dot < 9'd258)) || ((dot >= 9'd321) && (dot < 9'd338));
        cy  = '0;
        bi  = '0;
        pix = '0;
        pal = '0;
        pidx = '0;
        pv8 = pal_reg[tbvu_pkg::pal_index(a14[4:0])] & (mask_reg[0] ? 8'h30 : 8'h3F);

        if (accept)
        begin
            case (in_req.req_type)
                tbvu_pkg::REQ_READ:
                begin
                    if (in_req.reg_index == tbvu_pkg::REG_STATUS)
                    begin
                        rd_next   = {vbl_reg, 2'b00, rbuf_next[4:0]};
                        vbl_next  = 1'b0;
                        wtog_next = 1'b0;
                    end
                    else if (in_req.reg_index == tbvu_pkg::REG_DATA)
                    begin
                        rd_next = rbuf_next;
                        if (a14[13:8] == 6'h3F)
                        begin
                            rbuf_next = pv8;
                            rd_next   = pv8;
                        end
                        else if (!a14[13])
                        begin
                            pat_re = 1'b1;
                            pat_ra = a14[12:0];
                            pend_next = tbvu_pkg::PEND_BUF;
                            pend_pat_next = 1'b1;
                        end
                        else
                        begin
                            nt_re = 1'b1;
                            nt_ra = {mirr_reg ? a14[11] : a14[10], a14[9:0]};
                            pend_next = tbvu_pkg::PEND_BUF;
                        end
                        v_next = v_reg + (ctrl_reg[2] ? 15'd32 : 15'd1);
                    end
                end
                tbvu_pkg::REQ_WRITE:
                begin
                    case (in_req.reg_index)
                        tbvu_pkg::REG_CTRL:
                        begin
                            ctrl_next = in_req.write_data;
                            t_next[11:10] = in_req.write_data[1:0];
                        end
                        tbvu_pkg::REG_MASK:
                        begin
                            mask_next = in_req.write_data;
                        end
                        tbvu_pkg::REG_SCROLL:
                        begin
                            if (!wtog_reg)
                            begin
                                fx_next = in_req.write_data[2:0];
                                t_next[4:0] = in_req.write_data[7:3];
                            end
                            else
                            begin
                                t_next[14:12] = in_req.write_data[2:0];
                                t_next[9:5]   = in_req.write_data[7:3];
                            end
                            wtog_next = !wtog_reg;
                        end
                        tbvu_pkg::REG_ADDR:
                        begin
                            if (!wtog_reg)
                            begin
                                t_next = {1'b0, in_req.write_data[5:0], t_reg[7:0]};
                            end
                            else
                            begin
                                t_next = {t_reg[14:8], in_req.write_data};
                                v_next = {t_reg[14:8], in_req.write_data};
                            end
                            wtog_next = !wtog_reg;
                        end
                        tbvu_pkg::REG_DATA:
                        begin
                            if (!a14[13])
                            begin
                                pat_we = 1'b1;
                                pat_wa = a14[12:0];
                                pat_wd = in_req.write_data;
                            end
                            else if (a14[13:8] != 6'h3F)
                            begin
                                nt_we = 1'b1;
                                nt_wa = {mirr_reg ? a14[11] : a14[10], a14[9:0]};
                                nt_wd = in_req.write_data;
                            end
                            else
                            begin
                                pal_we = 1'b1;
                                pal_wa = tbvu_pkg::pal_index(a14[4:0]);
                                pal_wd = in_req.write_data;
                            end
                            v_next = v_reg + (ctrl_reg[2] ? 15'd32 : 15'd1);
                        end
                        default:
                        begin
                        end
                    endcase
                end
                tbvu_pkg::REQ_TICK:
                begin
                    if ((line < 9'd240) || (line == 9'd261))
                    begin
                        if ((line == 9'd261) && (dot == 9'd1))
                        begin
                            vbl_next = 1'b0;
                        end
                        if (window)
                        begin
                            if (mask_reg[3])
                            begin
                                spl_next = {spl_next[14:0], 1'b0};
                                sph_next = {sph_next[14:0], 1'b0};
                                sal_next = {sal_next[14:0], 1'b0};
                                sah_next = {sah_next[14:0], 1'b0};
                            end
                            case (dm1[2:0])
                                3'd0:
                                begin
                                    spl_next[7:0] = lo_next;
                                    sph_next[7:0] = hi_next;
                                    sal_next[7:0] = {8{attr_next[0]}};
                                    sah_next[7:0] = {8{attr_next[1]}};
                                    nt_re = 1'b1;
                                    nt_ra = {mirr_reg ? v_next[11] : v_next[10], v_next[9:0]};
                                    pend_next = tbvu_pkg::PEND_ID;
                                end
                                3'd2:
                                begin
                                    // Attribute byte at 0x23C0 of the current nametable.
                                    nt_re = 1'b1;
                                    nt_ra = {mirr_reg ? v_next[11] : v_next[10],
                                             4'hF, v_next[9:7], v_next[4:2]};
                                    pend_next = tbvu_pkg::PEND_ATTR;
                                    pend_sh_next = {v_next[6], v_next[1]};
                                end
                                3'd4:
                                begin
                                    pat_re = 1'b1;
                                    pat_ra = {ctrl_reg[4], id_next, 1'b0, v_next[14:12]};
                                    pend_next = tbvu_pkg::PEND_LO;
                                    pend_pat_next = 1'b1;
                                end
                                3'd6:
                                begin
                                    pat_re = 1'b1;
                                    pat_ra = {ctrl_reg[4], id_next, 1'b1, v_next[14:12]};
                                    pend_next = tbvu_pkg::PEND_HI;
                                    pend_pat_next = 1'b1;
                                end
                                3'd7:
                                begin
                                    if (render)
                                    begin
                                        if (v_next[4:0] == 5'd31)
                                        begin
                                            v_next = {v_next[14:11], !v_next[10], v_next[9:5], 5'd0};
                                        end
                                        else
                                        begin
                                            v_next = v_next + 15'd1;
                                        end
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        if ((dot == 9'd256) && render)
                        begin
                            if (v_next[14:12] != 3'd7)
                            begin
                                v_next[14:12] = v_next[14:12] + 3'd1;
                            end
                            else
                            begin
                                v_next[14:12] = 3'd0;
                                cy = v_next[9:5];
                                if (cy == 5'd29)
                                begin
                                    cy = 5'd0;
                                    v_next[11] = !v_next[11];
                                end
                                else if (cy == 5'd31)
                                begin
                                    cy = 5'd0;
                                end
                                else
                                begin
                                    cy = cy + 5'd1;
                                end
                                v_next[9:5] = cy;
                            end
                        end
                        if (dot == 9'd257)
                        begin
                            spl_next[7:0] = lo_next;
                            sph_next[7:0] = hi_next;
                            sal_next[7:0] = {8{attr_next[0]}};
                            sah_next[7:0] = {8{attr_next[1]}};
                            if (render)
                            begin
                                v_next[10]  = t_reg[10];
                                v_next[4:0] = t_reg[4:0];
                            end
                        end
                        if ((dot == 9'd338) || (dot == 9'd340))
                        begin
                            nt_re = 1'b1;
                            nt_ra = {mirr_reg ? v_next[11] : v_next[10], v_next[9:0]};
                            pend_next = tbvu_pkg::PEND_ID;
                        end
                        if ((line == 9'd261) && (dot >= 9'd280) && (dot < 9'd305) && render)
                        begin
                            v_next[14:11] = t_reg[14:11];
                            v_next[9:5]   = t_reg[9:5];
                        end
                    end
                    if ((line == 9'd241) && (dot == 9'd1))
                    begin
                        vbl_next = 1'b1;
                        nmi_next = ctrl_reg[7];
                    end
                    if (mask_reg[3])
                    begin
                        bi  = 4'd15 - {1'b0, fx_reg};
                        pix = {sph_next[bi], spl_next[bi]};
                        pal = {sah_next[bi], sal_next[bi]};
                    end
                    if (pix == 2'd0)
                    begin
                        pal = 2'd0;
                    end
                    if ((line < 9'd240) && (dot >= 9'd1) && (dot <= 9'd256))
                    begin
                        pidx    = {1'b0, pal, pix};
                        pv_next = 1'b1;
                        px_next = dm1[7:0];
                        py_next = line[7:0];
                        ci_next = mask_reg[0] ? {pal_reg[pidx][5:4], 4'd0} : pal_reg[pidx][5:0];
                    end
                    if (dot == 9'd340)
                    begin
                        dot_next = 9'd0;
                        if (line == 9'd260)
                        begin
                            line_next = 9'd261;
                            fd_next   = 1'b1;
                        end
                        else if (line >= 9'd261)
                        begin
                            line_next = 9'd0;
                        end
                        else
                        begin
                            line_next = line + 9'd1;
                        end
                    end
                    else
                    begin
                        dot_next = dot + 9'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            pat_mem[clr_cnt_reg] <= 8'd0;
        end
        else if (pat_we)
        begin
            pat_mem[pat_wa] <= pat_wd;
        end
        if (pat_re)
        begin
            pat_q <= pat_mem[pat_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            nt_mem[clr_cnt_reg[10:0]] <= 8'd0;
        end
        else if (nt_we)
        begin
            nt_mem[nt_wa] <= nt_wd;
        end
        if (nt_re)
        begin
            nt_q <= nt_mem[nt_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
            begin
                pal_reg[i] <= 8'd0;
            end
        end
        else if (pal_we)
        begin
            pal_reg[pal_wa] <= pal_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            mirr_reg      <= 1'b0;
            ctrl_reg      <= '0;
            mask_reg      <= '0;
            vbl_reg       <= 1'b0;
            wtog_reg      <= 1'b0;
            rbuf_reg      <= '0;
            v_reg         <= '0;
            t_reg         <= '0;
            fx_reg        <= '0;
            id_reg        <= '0;
            attr_reg      <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            spl_reg       <= '0;
            sph_reg       <= '0;
            sal_reg       <= '0;
            sah_reg       <= '0;
            line_reg      <= '0;
            dot_reg       <= '0;
            pend_reg      <= tbvu_pkg::PEND_NONE;
            pend_pat_reg  <= 1'b0;
            pend_sh_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 13'd1;
                if (clr_cnt_reg == 13'h1FFF)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (cfg_we)
            begin
                mirr_reg <= cfg_wdata;
            end
            ctrl_reg     <= ctrl_next;
            mask_reg     <= mask_next;
            vbl_reg      <= vbl_next;
            wtog_reg     <= wtog_next;
            rbuf_reg     <= rbuf_next;
            v_reg        <= v_next;
            t_reg        <= t_next;
            fx_reg       <= fx_next;
            id_reg       <= id_next;
            attr_reg     <= attr_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            spl_reg      <= spl_next;
            sph_reg      <= sph_next;
            sal_reg      <= sal_next;
            sah_reg      <= sah_next;
            line_reg     <= line_next;
            dot_reg      <= dot_next;
            pend_reg     <= pend_next;
            pend_pat_reg <= pend_pat_next;
            pend_sh_reg  <= pend_sh_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg  <= rd_next;
            pv_reg  <= pv_next;
            px_reg  <= px_next;
            py_reg  <= py_next;
            ci_reg  <= ci_next;
            nmi_reg <= nmi_next;
            fd_reg  <= fd_next;
        end
    end

    assign out_res.valid       = out_valid_reg;
    assign out_res.read_data   = rd_reg;
    assign out_res.pixel_valid = pv_reg;
    assign out_res.pixel_x     = px_reg;
    assign out_res.pixel_y     = py_reg;
    assign out_res.color_index = ci_reg;
    assign out_res.nmi_raise   = nmi_reg;
    assign out_res.frame_done  = fd_reg;

    `TBVU_ASSERT_SAME(a_clear_blocks_input, clr_busy_reg, !in_ready)
    `TBVU_ASSERT_SAME(a_raster_range, 1'b1, (dot_reg < 9'd341) && (line_reg <= 9'd261))
    `TBVU_ASSERT_NEXT(a_attr_read_forwarded, pend_next == tbvu_pkg::PEND_ATTR, pend_reg == tbvu_pkg::PEND_ATTR)
    `TBVU_ASSERT_NEXT(a_pending_needs_request, !accept, pend_reg == tbvu_pkg::PEND_NONE)

endmodule
